/* hw/rtl/spe_pkg.sv */
// ----------------------------------------------------------------------------
// spe_pkg
// Shared types and constants for the sparse polynomial evaluator.
// ----------------------------------------------------------------------------
package spe_pkg;

    localparam int DATA_W           = 32;
    localparam int EXP_W            = 5;
    localparam int MAX_EXPONENT_DEF = 31;
    localparam int NUM_VARS         = 3;
    localparam int CFG_INDEX_W      = 2;

    typedef logic [1:0] var_idx_t;

    // register indexes on the configuration channel
    localparam logic [CFG_INDEX_W-1:0] REG_POINT_X = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_POINT_Y = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_POINT_Z = 2'd2;

    // variable selectors
    localparam var_idx_t VAR_X = 2'd0;
    localparam var_idx_t VAR_Y = 2'd1;
    localparam var_idx_t VAR_Z = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic     load_term;   // capture coefficient, exponents, last flag
        logic     load_var;    // load base and exponent of var_idx
        var_idx_t var_idx;
        logic     mul_acc;     // acc <= acc * sq, clear exponent lsb
        logic     sqr;         // sq <= sq * sq, exponent >> 1
        logic     accum;       // sum <= sum + acc
        logic     emit;        // result <= sum + acc, sum <= 0
    } spe_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic exp_zero;
        logic exp_lsb;
        logic last;
    } spe_status_t;

endpackage

/* hw/rtl/spe_ifs.sv */
// ----------------------------------------------------------------------------
// spe_ifs
// Valid/ready channels of the evaluator: terms in, results out, config writes.
// ----------------------------------------------------------------------------
interface spe_term_if;
    logic                            valid;
    logic                            ready;
    logic signed [spe_pkg::DATA_W-1:0] coefficient;
    logic [spe_pkg::EXP_W-1:0]       exp_x;
    logic [spe_pkg::EXP_W-1:0]       exp_y;
    logic [spe_pkg::EXP_W-1:0]       exp_z;
    logic                            last_term;

    modport source (output valid, coefficient, exp_x, exp_y, exp_z, last_term,
                    input ready);
    modport sink   (input valid, coefficient, exp_x, exp_y, exp_z, last_term,
                    output ready);
endinterface

interface spe_result_if;
    logic                              valid;
    logic                              ready;
    logic signed [spe_pkg::DATA_W-1:0] poly_value;

    modport source (output valid, poly_value, input ready);
    modport sink   (input valid, poly_value, output ready);
endinterface

interface spe_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [spe_pkg::CFG_INDEX_W-1:0]  index;
    logic [spe_pkg::DATA_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/spe_datapath.sv */
// ----------------------------------------------------------------------------
// spe_datapath
// Point registers, one shared 32x32 multiplier whose product is written straight
// into acc or sq, square-and-multiply operands, running sum and result register.
// ----------------------------------------------------------------------------
module spe_datapath #(
    parameter int MAX_EXPONENT = spe_pkg::MAX_EXPONENT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [spe_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [spe_pkg::DATA_W-1:0]        cfg_data,
    input  logic signed [spe_pkg::DATA_W-1:0] coefficient,
    input  logic [spe_pkg::EXP_W-1:0]         exp_x,
    input  logic [spe_pkg::EXP_W-1:0]         exp_y,
    input  logic [spe_pkg::EXP_W-1:0]         exp_z,
    input  logic                              last_term,
    input  spe_pkg::spe_cmd_t                 cmd,
    output spe_pkg::spe_status_t              status,
    output logic signed [spe_pkg::DATA_W-1:0] poly_value
);

    localparam int EW  = (MAX_EXPONENT > 1) ? $clog2(MAX_EXPONENT + 1) : 1;
    localparam int CW  = 7;  // compare width, holds 0..127
    localparam int DW  = spe_pkg::DATA_W;

    logic [DW-1:0] point_reg [spe_pkg::NUM_VARS];
    logic [EW-1:0] exps_reg  [spe_pkg::NUM_VARS];
    logic [EW-1:0] exps_next [spe_pkg::NUM_VARS];
    logic [DW-1:0] acc_reg;
    logic [DW-1:0] sq_reg;
    logic [EW-1:0] exp_reg;
    logic [DW-1:0] sum_reg;
    logic [DW-1:0] sum_next;
    logic [DW-1:0] out_reg;
    logic          last_reg;
    logic [EW-1:0] exp_sel;
    logic [DW-1:0] base_sel;
    logic [DW-1:0] op_a;
    logic [DW-1:0] prod;
    logic [spe_pkg::EXP_W-1:0] exp_in [spe_pkg::NUM_VARS];

    assign exp_in[0] = exp_x;
    assign exp_in[1] = exp_y;
    assign exp_in[2] = exp_z;

    // exponents above the limit saturate
    always_comb
    begin
        for (int i = 0; i < spe_pkg::NUM_VARS; i++)
        begin
            if (CW'(exp_in[i]) > CW'(MAX_EXPONENT))
                exps_next[i] = EW'(MAX_EXPONENT);
            else
                exps_next[i] = EW'(exp_in[i]);
        end
    end

    always_comb
    begin
        unique case (cmd.var_idx)
            spe_pkg::VAR_X:
            begin
                base_sel = point_reg[0];
                exp_sel  = exps_reg[0];
            end
            spe_pkg::VAR_Y:
            begin
                base_sel = point_reg[1];
                exp_sel  = exps_reg[1];
            end
            spe_pkg::VAR_Z:
            begin
                base_sel = point_reg[2];
                exp_sel  = exps_reg[2];
            end
            default:
            begin
                base_sel = '0;
                exp_sel  = '0;
            end
        endcase
    end

    // one multiply per cycle, product lands straight in acc or sq
    assign op_a      = cmd.mul_acc ? acc_reg : sq_reg;
    assign prod      = op_a * sq_reg;
    assign sum_next  = sum_reg + acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < spe_pkg::NUM_VARS; i++)
                point_reg[i] <= '0;
            sum_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    spe_pkg::REG_POINT_X: point_reg[0] <= cfg_data;
                    spe_pkg::REG_POINT_Y: point_reg[1] <= cfg_data;
                    spe_pkg::REG_POINT_Z: point_reg[2] <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.emit)
                sum_reg <= '0;
            else if (cmd.accum)
                sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_term)
        begin
            acc_reg  <= coefficient;
            last_reg <= last_term;
            for (int i = 0; i < spe_pkg::NUM_VARS; i++)
                exps_reg[i] <= exps_next[i];
        end
        else if (cmd.mul_acc)
        begin
            acc_reg <= prod;
        end
        if (cmd.load_var)
        begin
            sq_reg  <= base_sel;
            exp_reg <= exp_sel;
        end
        else if (cmd.mul_acc)
        begin
            exp_reg[0] <= 1'b0;
        end
        else if (cmd.sqr)
        begin
            sq_reg  <= prod;
            exp_reg <= exp_reg >> 1;
        end
        if (cmd.emit)
            out_reg <= sum_next;
    end

    assign status.exp_zero = (exp_reg == '0);
    assign status.exp_lsb  = exp_reg[0];
    assign status.last     = last_reg;
    assign poly_value      = out_reg;

endmodule

/* hw/rtl/spe_controller.sv */
// ----------------------------------------------------------------------------
// spe_controller
// Sequencer: takes a term, walks x, y, z through square-and-multiply on the
// datapath, then accumulates and hands the sum to the output register.
// ----------------------------------------------------------------------------
module spe_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  spe_pkg::spe_status_t status,
    output spe_pkg::spe_cmd_t    cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LOAD  = 2'd1;
    localparam logic [1:0] S_STEP  = 2'd2;
    localparam logic [1:0] S_ACCUM = 2'd3;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    spe_pkg::var_idx_t var_reg;
    spe_pkg::var_idx_t var_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_busy;

    assign out_busy = out_valid_reg && !out_ready;

    always_comb
    begin
        cmd        = '0;
        cmd.var_idx = var_reg;
        state_next = state_reg;
        var_next   = var_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_term = 1'b1;
                    var_next      = spe_pkg::VAR_X;
                    state_next    = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load_var = 1'b1;
                state_next   = S_STEP;
            end
            S_STEP:
            begin
                priority if (status.exp_zero)
                begin
                    if (var_reg == spe_pkg::VAR_Z)
                        state_next = S_ACCUM;
                    else
                    begin
                        var_next   = var_reg + 2'd1;
                        state_next = S_LOAD;
                    end
                end
                else if (status.exp_lsb)
                    cmd.mul_acc = 1'b1;
                else
                    cmd.sqr = 1'b1;
            end
            S_ACCUM:
            begin
                if (!status.last)
                begin
                    cmd.accum  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (!out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.emit || out_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            var_reg       <= spe_pkg::VAR_X;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            var_reg       <= var_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* hw/rtl/sparse_polynomial_evaluator.sv */
// ----------------------------------------------------------------------------
// sparse_polynomial_evaluator
// Evaluates a streamed sparse polynomial in x, y, z at the configured point.
//
//   channel | dir | payload                                    | beat
//   term    | in  | coefficient, exp_x, exp_y, exp_z, last_term | one term
//   result  | out | poly_value                                 | one sum
//   cfg     | in  | index, data                                | one reg write
//
// A term walks x, y and z in turn through square-and-multiply on its saturated
// exponent; a zero exponent needs no multiply. The one shared 32x32 multiplier
// gives one product per cycle. A new term is taken only once the one before it
// is done.
// A finished sum sits in the output register; the next term is taken while
// it waits. Only a last term stalls, and only while that register is full.
// rst_n clears the point registers, running sum and control; cfg is always ready.
// ----------------------------------------------------------------------------
module sparse_polynomial_evaluator #(
    parameter int MAX_EXPONENT = spe_pkg::MAX_EXPONENT_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    spe_term_if.sink       term,
    spe_result_if.source   result,
    spe_cfg_if.sink        cfg
);

    spe_pkg::spe_cmd_t    cmd;
    spe_pkg::spe_status_t status;

    assign cfg.ready = 1'b1;

    spe_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (term.valid),
        .in_ready  (term.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    spe_datapath #(
        .MAX_EXPONENT (MAX_EXPONENT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg.valid && cfg.ready),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .coefficient (term.coefficient),
        .exp_x       (term.exp_x),
        .exp_y       (term.exp_y),
        .exp_z       (term.exp_z),
        .last_term   (term.last_term),
        .cmd         (cmd),
        .status      (status),
        .poly_value  (result.poly_value)
    );

    // a taken term keeps the input closed until its work is done
    a_term_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (term.valid && term.ready) |=> !term.ready)
        else $error("term accepted twice in a row");

    // the output register is only loaded when it is free
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(result.valid && !result.ready))
        else $error("result overwritten while waiting");

    // a result is never produced in the cycle a term is taken
    a_emit_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !term.ready)
        else $error("emit while idle");

endmodule
